/* rtl/ssl_pkg.sv */
package ssl_pkg;

    localparam int SERVO_COUNT  = 4;
    localparam int PULSE_MIN_US = 500;
    localparam int PULSE_MAX_US = 2500;
    localparam int FULL_SWING   = 180;

    localparam int SERVO_W  = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int NUM_W    = 3;
    localparam int ANGLE_W  = 8;
    localparam int PULSE_W  = 12;
    localparam int MODE_W   = 3;
    localparam int CFG_W    = 32;
    localparam int PERIOD_W = 16;
    localparam int CFG_IDX_W = 2;

    // pulse = angle * span / 180 + min, division done by exact reciprocal multiply
    localparam int SPAN        = PULSE_MAX_US - PULSE_MIN_US;
    localparam int PROD_W      = ANGLE_W + $clog2(SPAN + 1);
    localparam int RECIP_SHIFT = PROD_W + $clog2(FULL_SWING);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + FULL_SWING - 1) / FULL_SWING;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int QUOT_W  = PROD_W + RECIP_W - RECIP_SHIFT;
    localparam int SUM_W   = QUOT_W + PULSE_W;
    localparam logic [PULSE_W-1:0] PULSE_TOP = '1;

    localparam logic [ANGLE_W-1:0]  ANGLE_RESET  = 8'd90;
    localparam logic [PERIOD_W-1:0] TICK_MAX     = '1;
    localparam logic [CFG_W-1:0]    MIN_RESET    = 32'h0000_0000;
    localparam logic [CFG_W-1:0]    MAX_RESET    = 32'hB4B4_B4B4;
    localparam logic [CFG_W-1:0]    START_RESET  = 32'h5A5A_5A5A;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20;

    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GO_MIN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GO_MAX   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GO_ANGLE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INIT     = 3'd5;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_PULSE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0]    min_angles;
        logic [CFG_W-1:0]    max_angles;
        logic [CFG_W-1:0]    start_angles;
        logic [PERIOD_W-1:0] step_period;
    } t_cfg;

    typedef logic [SERVO_COUNT-1:0] t_mask;

    // bytes past the register width read as zero
    function automatic logic [ANGLE_W-1:0] packed_byte(input logic [CFG_W-1:0] word_v,
                                                       input logic [SERVO_W-1:0] sel);
        logic [8*ANGLE_W-1:0] wide;
        wide = (8*ANGLE_W)'(word_v);
        return wide[sel*ANGLE_W +: ANGLE_W];
    endfunction

endpackage

/* rtl/servo_slew_limiter_unit.sv */
// command: checked in S_CMD, ack loaded in S_ACK once output is free; input stalled until idle
// tick below the step period: tick count advanced, input not stalled, no result
// step or init: S_SCAN angle scan over every servo, then S_FIND skips unmoved servos and
// S_MAP/S_EMIT map and emit one pulse beat per moved servo (two-stage shared pulse
// multiplier); step with no motion returns to idle from S_FIND; output stalls hold S_EMIT
// sync active-low reset: angles 90, tick count zero, config registers to their reset values
module servo_slew_limiter_unit
    import ssl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [NUM_W-1:0]     i_servo_index,
    input  logic [ANGLE_W-1:0]   i_angle,
    input  logic                 i_angle_present,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic                 o_accepted,
    output logic [NUM_W-1:0]     o_servo_number,
    output logic [PULSE_W-1:0]   o_pulse_us,
    output logic                 o_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_CMD, S_ACK, S_SCAN, S_FIND, S_MAP, S_EMIT
    } t_state;

    t_state r_state;

    t_cfg cfg;

    logic [ANGLE_W-1:0]  r_cur [SERVO_COUNT];
    logic [ANGLE_W-1:0]  r_tgt [SERVO_COUNT];
    logic [PERIOD_W-1:0] r_tick;
    t_mask               r_mask;
    logic [SERVO_W-1:0]  r_idx;
    logic                r_is_init;
    logic [MODE_W-1:0]   r_cmd_mode;
    logic [NUM_W-1:0]    r_cmd_idx;
    logic [ANGLE_W-1:0]  r_cmd_angle;
    logic                r_cmd_present;
    logic                r_ok;

    logic                r_out_valid;
    logic                r_kind;
    logic                r_accepted;
    logic [NUM_W-1:0]    r_servo_number;
    logic [PULSE_W-1:0]  r_pulse_us;
    logic                r_last;

    logic [SERVO_W-1:0]  sel_idx;
    logic [ANGLE_W-1:0]  cur_a;
    logic [ANGLE_W-1:0]  tgt_a;
    logic [ANGLE_W-1:0]  lo;
    logic [ANGLE_W-1:0]  hi;
    logic [ANGLE_W-1:0]  st;
    logic                idx_ok;
    logic                cmd_ok;
    logic                idx_last;
    logic                out_free;
    logic [PERIOD_W-1:0] tick_next;
    t_mask               rest;
    logic [PULSE_W-1:0]  pulse;

    ssl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ssl_pulse_map u_map (
        .i_clk   (i_clk),
        .i_angle (cur_a),
        .o_pulse (pulse)
    );

    // single angle read port: command index or sequencer index
    assign sel_idx  = (r_state == S_CMD) ? r_cmd_idx[SERVO_W-1:0] : r_idx;
    assign cur_a    = r_cur[sel_idx];
    assign tgt_a    = r_tgt[sel_idx];
    assign lo       = packed_byte(cfg.min_angles, sel_idx);
    assign hi       = packed_byte(cfg.max_angles, sel_idx);
    assign st       = packed_byte(cfg.start_angles, sel_idx);
    assign idx_ok   = {1'b0, r_cmd_idx} < (NUM_W+1)'(SERVO_COUNT);
    assign idx_last = (r_idx == SERVO_W'(SERVO_COUNT - 1));
    assign out_free = !r_out_valid || !i_out_stall;
    assign tick_next = (r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;

    always_comb begin
        cmd_ok = 1'b0;
        if (idx_ok) begin
            case (r_cmd_mode)
                MODE_GO_MIN, MODE_GO_MAX, MODE_STOP: cmd_ok = 1'b1;
                MODE_GO_ANGLE: begin
                    cmd_ok = r_cmd_present && r_cmd_angle >= lo && r_cmd_angle <= hi;
                end
                default: cmd_ok = 1'b0;
            endcase
        end
    end

    always_comb begin
        rest        = r_mask;
        rest[r_idx] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_mask      <= '0;
            r_idx       <= '0;
            r_is_init   <= 1'b0;
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_cur[i] <= ANGLE_RESET;
                r_tgt[i] <= ANGLE_RESET;
            end
        end else begin
            // the emitting states load the next beat themselves
            if (r_out_valid && !i_out_stall && r_state != S_ACK && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd_mode    <= i_mode;
                        r_cmd_idx     <= i_servo_index;
                        r_cmd_angle   <= i_angle;
                        r_cmd_present <= i_angle_present;
                        r_idx         <= '0;
                        r_mask        <= '0;
                        case (i_mode)
                            MODE_TICK: begin
                                if (tick_next > cfg.step_period) begin
                                    r_tick    <= '0;
                                    r_is_init <= 1'b0;
                                    r_state   <= S_SCAN;
                                end else begin
                                    r_tick <= tick_next;
                                end
                            end
                            MODE_INIT: begin
                                r_is_init <= 1'b1;
                                r_state   <= S_SCAN;
                            end
                            MODE_GO_MIN, MODE_GO_MAX, MODE_STOP, MODE_GO_ANGLE: begin
                                r_state <= S_CMD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CMD: begin
                    r_ok <= cmd_ok;
                    if (cmd_ok) begin
                        case (r_cmd_mode)
                            MODE_GO_MIN:   r_tgt[sel_idx] <= lo;
                            MODE_GO_MAX:   r_tgt[sel_idx] <= hi;
                            MODE_STOP:     r_tgt[sel_idx] <= cur_a;
                            MODE_GO_ANGLE: r_tgt[sel_idx] <= r_cmd_angle;
                            default: ;
                        endcase
                    end
                    r_state <= S_ACK;
                end
                S_ACK: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_kind         <= KIND_ACK;
                        r_accepted     <= r_ok;
                        r_servo_number <= '0;
                        r_pulse_us     <= '0;
                        r_last         <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    // one servo per cycle: load start angle or take one degree step
                    if (r_is_init) begin
                        r_cur[r_idx]  <= st;
                        r_tgt[r_idx]  <= st;
                        r_mask[r_idx] <= 1'b1;
                    end else if (tgt_a > cur_a && cur_a < hi) begin
                        r_cur[r_idx]  <= cur_a + 1'b1;
                        r_mask[r_idx] <= 1'b1;
                    end else if (tgt_a < cur_a && cur_a > lo) begin
                        r_cur[r_idx]  <= cur_a - 1'b1;
                        r_mask[r_idx] <= 1'b1;
                    end
                    if (idx_last) begin
                        r_idx   <= '0;
                        r_state <= S_FIND;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIND: begin
                    if (r_mask == '0) begin
                        r_state <= S_IDLE;
                    end else if (r_mask[r_idx]) begin
                        r_state <= S_MAP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MAP: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_kind         <= KIND_PULSE;
                        r_accepted     <= 1'b0;
                        r_servo_number <= NUM_W'(r_idx);
                        r_pulse_us     <= pulse;
                        r_last         <= (rest == '0);
                        r_mask         <= rest;
                        if (rest == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_FIND;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_accepted     = r_accepted;
    assign o_servo_number = r_servo_number;
    assign o_pulse_us     = r_pulse_us;
    assign o_last         = r_last;

`ifndef SYNTH
    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_mask[r_idx])
        else $error("pulse beat for a servo that did not move");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_mask == '0))
        else $error("idle with pulse beats still owed");

    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_ACK) |-> (r_last && r_pulse_us == '0
                                                && r_servo_number == '0))
        else $error("malformed acknowledge beat");

    a_pulse_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_PULSE) |-> (r_pulse_us >= PULSE_W'(PULSE_MIN_US)
                                                  && !r_accepted))
        else $error("pulse beat below minimum width");
`endif

endmodule

/* rtl/ssl_cfg_regs.sv */
module ssl_cfg_regs
    import ssl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_angles   <= MIN_RESET;
            r_cfg.max_angles   <= MAX_RESET;
            r_cfg.start_angles <= START_RESET;
            r_cfg.step_period  <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_ANGLES:   r_cfg.min_angles   <= i_cfg_wdata;
                CFG_MAX_ANGLES:   r_cfg.max_angles   <= i_cfg_wdata;
                CFG_START_ANGLES: r_cfg.start_angles <= i_cfg_wdata;
                CFG_STEP_PERIOD:  r_cfg.step_period  <= i_cfg_wdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/ssl_pulse_map.sv */
module ssl_pulse_map
    import ssl_pkg::*;
(
    input  logic               i_clk,
    input  logic [ANGLE_W-1:0] i_angle,
    output logic [PULSE_W-1:0] o_pulse
);

    logic [PROD_W-1:0]         r_prod;
    logic [QUOT_W-1:0]         r_quot;
    logic [PROD_W+RECIP_W-1:0] full;
    logic [SUM_W-1:0]          sum;

    // two-stage: angle * span, then reciprocal multiply for the divide by 180
    assign full = (PROD_W+RECIP_W)'(r_prod) * (PROD_W+RECIP_W)'(RECIP);

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_angle) * PROD_W'(SPAN);
        r_quot <= full[RECIP_SHIFT +: QUOT_W];
    end

    assign sum     = SUM_W'(r_quot) + SUM_W'(PULSE_MIN_US);
    assign o_pulse = (sum > SUM_W'(PULSE_TOP)) ? PULSE_TOP : sum[PULSE_W-1:0];

endmodule
